@@ rtl/oar_pkg.sv @@
// ----------------------------------------------------------------------------
// oar_pkg: shared types and constants for the roaming controller
// Mode codes, register indexes, drive speeds and the structs that carry the
// configuration, the tick word and the controller state between modules.
// ----------------------------------------------------------------------------
package oar_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_MANUAL = 3'd1,
    MODE_FWD    = 3'd2,
    MODE_TURN   = 3'd3,
    MODE_BACK   = 3'd4,
    MODE_FAULT  = 3'd5
  } oar_mode_e;

  // configuration register indexes
  localparam logic [7:0] REG_STOP_DIST  = 8'd0;
  localparam logic [7:0] REG_SLOW_DIST  = 8'd1;
  localparam logic [7:0] REG_CLEAR_DIST = 8'd2;
  localparam logic [7:0] REG_TURN_TIME  = 8'd3;
  localparam logic [7:0] REG_BACK_TIME  = 8'd4;
  localparam logic [7:0] REG_HOLD_TIME  = 8'd5;
  localparam logic [7:0] REG_MAN_THR    = 8'd6;
  localparam logic [7:0] REG_MAX_ATT    = 8'd7;

  // drive speeds in permille
  localparam logic signed [10:0] FWD_SPEED       = 11'sd600;
  localparam logic signed [10:0] SLOW_SPEED      = 11'sd300;
  localparam logic signed [10:0] SLOW_TURN_SPEED = 11'sd250;
  localparam logic signed [10:0] PIVOT_SPEED     = 11'sd400;
  localparam logic signed [10:0] BACK_SPEED      = 11'sd300;
  localparam logic signed [10:0] DISARM_Y        = -11'sd900;
  localparam logic [10:0]        DISARM_X        = 11'd200;
  localparam logic signed [10:0] DRIVE_MAX       = 11'sd1000;
  localparam logic [15:0]        NO_DIST         = 16'hFFFF;

  typedef struct packed {
    logic [15:0] stop_distance;
    logic [15:0] slow_distance;
    logic [15:0] clear_distance;
    logic [15:0] turn_time;
    logic [15:0] back_time;
    logic [15:0] manual_hold_time;
    logic [9:0]  manual_threshold;
    logic [7:0]  max_turn_attempts;
  } oar_cfg_t;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic               link_online;
    logic               web_manual;
    logic signed [10:0] stick_x;
    logic signed [10:0] stick_y;
    logic               radar_online;
    logic [15:0]        front_mm;
    logic [15:0]        left_mm;
    logic [15:0]        right_mm;
  } oar_tick_t;

  typedef struct packed {
    oar_mode_e   mode;
    logic [31:0] state_start;
    logic [31:0] manual_until;
    logic        armed;
    logic        turn_right;
    logic [7:0]  attempt_count;
  } oar_state_t;

endpackage

@@ rtl/oar_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// oar_cfg_regs: configuration register file
// Takes indexed writes and holds the distance, timing and threshold settings.
// ----------------------------------------------------------------------------
module oar_cfg_regs
  import oar_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output oar_cfg_t    cfg_o
);

  oar_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_STOP_DIST:  cfg_d.stop_distance     = cfg_data_i;
        REG_SLOW_DIST:  cfg_d.slow_distance     = cfg_data_i;
        REG_CLEAR_DIST: cfg_d.clear_distance    = cfg_data_i;
        REG_TURN_TIME:  cfg_d.turn_time         = cfg_data_i;
        REG_BACK_TIME:  cfg_d.back_time         = cfg_data_i;
        REG_HOLD_TIME:  cfg_d.manual_hold_time  = cfg_data_i;
        REG_MAN_THR:    cfg_d.manual_threshold  = cfg_data_i[9:0];
        REG_MAX_ATT:    cfg_d.max_turn_attempts = cfg_data_i[7:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stop_distance     <= 16'd300;
      cfg_q.slow_distance     <= 16'd600;
      cfg_q.clear_distance    <= 16'd500;
      cfg_q.turn_time         <= 16'd600;
      cfg_q.back_time         <= 16'd800;
      cfg_q.manual_hold_time  <= 16'd1500;
      cfg_q.manual_threshold  <= 10'd100;
      cfg_q.max_turn_attempts <= 8'd3;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/oar_tick_logic.sv @@
// ----------------------------------------------------------------------------
// oar_tick_logic: one control tick of the roaming controller
// From the tick word, the current state and the settings, works out the next
// state and the drive command in one pass of compare and select logic.
// ----------------------------------------------------------------------------
module oar_tick_logic
  import oar_pkg::*;
(
  input  oar_tick_t          tick_i,
  input  oar_state_t         state_i,
  input  oar_cfg_t           cfg_i,
  output oar_state_t         state_o,
  output logic signed [10:0] drive_x_o,
  output logic signed [10:0] drive_y_o
);

  function automatic logic [10:0] abs11(logic signed [10:0] v);
    return v[10] ? 11'(-v) : 11'(v);
  endfunction

  function automatic logic signed [10:0] sat_drive(logic signed [10:0] v);
    if (v > DRIVE_MAX) begin
      return DRIVE_MAX;
    end else if (v < -DRIVE_MAX) begin
      return -DRIVE_MAX;
    end
    return v;
  endfunction

  // 1 = turn right
  function automatic logic pick_turn(logic [15:0] l, logic [15:0] r, logic cur_right);
    if (l == NO_DIST && r == NO_DIST) begin
      return ~cur_right;
    end else if (l == NO_DIST) begin
      return 1'b0;
    end else if (r == NO_DIST) begin
      return 1'b1;
    end
    return r > l;
  endfunction

  logic [10:0] abs_x, abs_y;
  logic        disarm, takeover, hold_run, front_valid, pick;
  logic [31:0] hold_diff, elapsed, hold_end;
  oar_mode_e   work_mode;

  assign abs_x       = abs11(tick_i.stick_x);
  assign abs_y       = abs11(tick_i.stick_y);
  assign disarm      = (tick_i.stick_y <= DISARM_Y) && (abs_x < DISARM_X);
  assign takeover    = (abs_x > {1'b0, cfg_i.manual_threshold}) ||
                       (abs_y > {1'b0, cfg_i.manual_threshold});
  assign hold_diff   = tick_i.now_ms - state_i.manual_until;
  assign hold_run    = (state_i.mode == MODE_MANUAL) && hold_diff[31];
  assign hold_end    = tick_i.now_ms + {16'd0, cfg_i.manual_hold_time};
  assign elapsed     = tick_i.now_ms - state_i.state_start;
  assign front_valid = tick_i.front_mm != NO_DIST;
  assign pick        = pick_turn(tick_i.left_mm, tick_i.right_mm, state_i.turn_right);
  // expired manual hold falls into forward on the same tick
  assign work_mode   = (state_i.mode == MODE_MANUAL) ? MODE_FWD : state_i.mode;

  always_comb begin
    state_o   = state_i;
    drive_x_o = '0;
    drive_y_o = '0;
    if (!tick_i.link_online) begin
      state_o.mode  = MODE_FAULT;
      state_o.armed = 1'b0;
    end else if (tick_i.web_manual) begin
      state_o.armed        = 1'b0;
      state_o.mode         = (tick_i.stick_x != '0 || tick_i.stick_y != '0) ?
                             MODE_MANUAL : MODE_IDLE;
      state_o.manual_until = tick_i.now_ms;
      drive_x_o            = sat_drive(tick_i.stick_x);
      drive_y_o            = sat_drive(tick_i.stick_y);
    end else if (disarm) begin
      state_o.armed = 1'b0;
      state_o.mode  = MODE_IDLE;
    end else if (takeover) begin
      state_o.armed        = 1'b1;
      state_o.mode         = MODE_MANUAL;
      state_o.manual_until = hold_end;
      drive_x_o            = sat_drive(tick_i.stick_x);
      drive_y_o            = sat_drive(tick_i.stick_y);
    end else if (!hold_run) begin
      if (state_i.mode == MODE_MANUAL) begin
        state_o.mode          = MODE_FWD;
        state_o.state_start   = tick_i.now_ms;
        state_o.attempt_count = '0;
      end
      if (!state_i.armed) begin
        state_o.mode = MODE_IDLE;
      end else if (!tick_i.radar_online) begin
        state_o.mode = MODE_FAULT;
      end else begin
        case (work_mode)
          MODE_FWD: begin
            if (front_valid && tick_i.front_mm < cfg_i.stop_distance) begin
              state_o.turn_right    = pick;
              state_o.mode          = MODE_TURN;
              state_o.state_start   = tick_i.now_ms;
              state_o.attempt_count = 8'd1;
            end else if (front_valid && tick_i.front_mm < cfg_i.slow_distance) begin
              drive_y_o = SLOW_SPEED;
              drive_x_o = pick ? SLOW_TURN_SPEED : -SLOW_TURN_SPEED;
            end else begin
              drive_y_o = FWD_SPEED;
            end
          end
          MODE_TURN: begin
            drive_x_o = state_i.turn_right ? PIVOT_SPEED : -PIVOT_SPEED;
            if (elapsed >= {16'd0, cfg_i.turn_time}) begin
              if (!front_valid || tick_i.front_mm > cfg_i.clear_distance) begin
                state_o.mode = MODE_FWD;
              end else if (state_i.attempt_count < cfg_i.max_turn_attempts) begin
                state_o.turn_right    = ~state_i.turn_right;
                state_o.attempt_count = state_i.attempt_count + 8'd1;
              end else begin
                state_o.mode = MODE_BACK;
              end
              state_o.state_start = tick_i.now_ms;
            end
          end
          MODE_BACK: begin
            drive_y_o = -BACK_SPEED;
            drive_x_o = state_i.turn_right ? -SLOW_TURN_SPEED : SLOW_TURN_SPEED;
            if (elapsed >= {16'd0, cfg_i.back_time}) begin
              // retry the pivot the other way
              state_o.turn_right    = ~state_i.turn_right;
              state_o.mode          = MODE_TURN;
              state_o.state_start   = tick_i.now_ms;
              state_o.attempt_count = '0;
            end
          end
          default: begin
            state_o.mode = MODE_IDLE;
          end
        endcase
      end
    end
  end

endmodule

@@ rtl/obstacle_avoid_roam_fsm_unit.sv @@
// ----------------------------------------------------------------------------
// obstacle_avoid_roam_fsm_unit: roaming controller with obstacle avoidance
// Pipeline: a tick word goes into the input register at acceptance, and the
// tick logic result goes into the result register once that register frees.
// Throughput: one tick word per cycle while the output is not stalled; the
// combinational tick logic and its state register close the word-to-word loop.
// Reset: asynchronous, clears the pipeline valids and the controller state
// (idle, disarmed, turn right) and loads the default settings.
// ----------------------------------------------------------------------------
module obstacle_avoid_roam_fsm_unit
  import oar_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // settings
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  // tick words
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        now_ms_i,
  input  logic               link_online_i,
  input  logic               web_manual_i,
  input  logic signed [10:0] stick_x_i,
  input  logic signed [10:0] stick_y_i,
  input  logic               radar_online_i,
  input  logic [15:0]        front_mm_i,
  input  logic [15:0]        left_mm_i,
  input  logic [15:0]        right_mm_i,
  // drive commands
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [10:0] drive_x_o,
  output logic signed [10:0] drive_y_o,
  output logic [2:0]         mode_o
);

  oar_cfg_t           cfg;
  oar_tick_t          tick_q;
  oar_state_t         state_q, state_d;
  logic               in_valid_q, out_valid_q, advance;
  logic signed [10:0] drive_x_d, drive_y_d, drive_x_q, drive_y_q;
  oar_mode_e          mode_q;

  oar_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  oar_tick_logic u_tick (
    .tick_i    (tick_q),
    .state_i   (state_q),
    .cfg_i     (cfg),
    .state_o   (state_d),
    .drive_x_o (drive_x_d),
    .drive_y_o (drive_y_d)
  );

  // the result register frees when empty or taken this cycle
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q             <= 1'b0;
      out_valid_q            <= 1'b0;
      state_q.mode           <= MODE_IDLE;
      state_q.state_start    <= '0;
      state_q.manual_until   <= '0;
      state_q.armed          <= 1'b0;
      state_q.turn_right     <= 1'b1;
      state_q.attempt_count  <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (in_valid_q && advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      tick_q.now_ms       <= now_ms_i;
      tick_q.link_online  <= link_online_i;
      tick_q.web_manual   <= web_manual_i;
      tick_q.stick_x      <= stick_x_i;
      tick_q.stick_y      <= stick_y_i;
      tick_q.radar_online <= radar_online_i;
      tick_q.front_mm     <= front_mm_i;
      tick_q.left_mm      <= left_mm_i;
      tick_q.right_mm     <= right_mm_i;
    end
    if (in_valid_q && advance) begin
      drive_x_q <= drive_x_d;
      drive_y_q <= drive_y_d;
      mode_q    <= state_d.mode;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_x_o   = drive_x_q;
  assign drive_y_o   = drive_y_q;
  assign mode_o      = mode_q;

  // input side stalls only behind a blocked result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // a disarmed controller never sits in an autonomous mode
  a_disarmed_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.armed |-> (state_q.mode == MODE_IDLE || state_q.mode == MODE_MANUAL ||
                        state_q.mode == MODE_FAULT))
    else $error("autonomous mode while disarmed");

  // fault always commands a stop
  a_fault_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && mode_o == MODE_FAULT) |-> (drive_x_o == '0 && drive_y_o == '0))
    else $error("nonzero drive in fault");

  // drive commands stay within full scale
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (drive_x_o <= DRIVE_MAX && drive_x_o >= -DRIVE_MAX &&
                     drive_y_o <= DRIVE_MAX && drive_y_o >= -DRIVE_MAX))
    else $error("drive command out of range");

endmodule
